### design/rtjm_pkg.sv
// Package for the radial touch joystick mapper.
// Holds the beat structs, the register map, the command and status codes.
// No dependencies.
package rtjm_pkg;

   localparam int CFG_W    = 12;
   localparam int COORD_BITS = 12;
   localparam int ID_W     = 7;
   localparam int STATUS_W = 2;
   localparam int AXIS_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic CMD_TOUCH   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INNER  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ACTIVE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_RAD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_RAD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_RAD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_X     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_Y     = 3'd6;

   typedef struct packed {
      logic             cmd;
      logic [ID_W-1:0]  finger;
      logic [CFG_W-1:0] touch_x;
      logic [CFG_W-1:0] touch_y;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      touch_status;
      logic signed [AXIS_W-1:0] axis_x;
      logic signed [AXIS_W-1:0] axis_y;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] center_x;
      logic [CFG_W-1:0] center_y;
      logic [CFG_W-1:0] active_radius;
      logic [CFG_W-1:0] inner_dead_radius;
      logic [CFG_W-1:0] outer_dead_radius;
      logic             invert_x_axis;
      logic             invert_y_axis;
   } cfg_type;

endpackage

### design/rtjm_queue.sv
// Small first-in first-out queue of registers between the front and back ends.
// Generic width and depth; no package dependency.
module rtjm_queue #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output logic [W-1:0] head
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

### design/rtjm_front.sv
// Front end: accepts touch beats and turns coordinates into signed offsets.
// Depends on rtjm_pkg; feeds rtjm_queue.
module rtjm_front #(
   parameter int COORD_BITS = 12,
   parameter int MW         = 12,
   parameter int EW         = 1 + rtjm_pkg::ID_W + 2 * (MW + 1)
) (
   input  rtjm_pkg::req_type          req_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rtjm_pkg::CFG_W-1:0] center_x,
   input  logic [rtjm_pkg::CFG_W-1:0] center_y,
   input  logic                       q_full,
   output logic                       q_push,
   output logic [EW-1:0]              q_data
);
   import rtjm_pkg::*;

   localparam logic [MW-1:0] CMASK = MW'((32'd1 << COORD_BITS) - 32'd1);

   logic [MW-1:0] tx, ty, ax, ay;
   logic [MW:0]   dx, dy;

   assign tx = MW'(req_data.touch_x) & CMASK;
   assign ty = MW'(req_data.touch_y) & CMASK;
   assign dx = {1'b0, tx} - {1'b0, MW'(center_x)};
   assign dy = {1'b0, ty} - {1'b0, MW'(center_y)};
   assign ax = dx[MW] ? MW'(-dx) : dx[MW-1:0];
   assign ay = dy[MW] ? MW'(-dy) : dy[MW-1:0];

   assign req_stall = q_full;
   assign q_push    = req_valid;
   assign q_data    = {req_data.cmd, req_data.finger, dx[MW], ax, dy[MW], ay};
endmodule

### design/rtjm_back.sv
// Back end: ownership tracking, zone classification, serial divider and square root.
// Depends on rtjm_pkg; reads entries from rtjm_queue and drives the result beat.
module rtjm_back #(
   parameter int MW        = 12,
   parameter int FRAC_BITS = 15,
   parameter int EW        = 1 + rtjm_pkg::ID_W + 2 * (MW + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  rtjm_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  logic [EW-1:0]     q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtjm_pkg::rsp_type rsp_data
);
   import rtjm_pkg::*;

   localparam int F          = FRAC_BITS;
   localparam int SQW        = 2 * MW;
   localparam int DVW        = 2 * MW + 1;
   localparam int LIN_STEPS  = MW + F + 2;
   localparam int NORM_STEPS = 2 * F + 2;
   localparam int QW         = (LIN_STEPS > NORM_STEPS) ? LIN_STEPS : NORM_STEPS;
   localparam int CNTW       = $clog2(QW + 1);
   localparam int RW         = F + 2;
   localparam int SRW        = F + 5;
   localparam int DRW        = 2 * F + 4;
   localparam logic [QW-1:0] AXIS_MAX = QW'((32'd1 << F) - 32'd1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SQ    = 8'b0000_0010,
      ST_CLASS = 8'b0000_0100,
      ST_DIVL  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_SQRT  = 8'b0010_0000,
      ST_AXIS  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic                 q_cmd, q_sx, q_sy;
   logic [ID_W-1:0]      q_fid;
   logic [MW-1:0]        q_ax, q_ay;

   logic [ID_W-1:0]      fid_ff, fid_in;
   logic [MW-1:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic                 sx_ff, sx_in, sy_ff, sy_in;
   logic [SQW-1:0]       sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SQW-1:0]       ar2_ff, ar2_in, ir2_ff, ir2_in, or2_ff, or2_in;
   logic [DVW-1:0]       t2_ff, t2_in;
   logic [2:0]           step_ff, step_in;
   logic                 norm_ff, norm_in, axis_ff, axis_in, q0_ff, q0_in;
   logic [DVW-1:0]       rem_ff, rem_in;
   logic [QW-1:0]        numq_ff, numq_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [DRW-1:0]       dreg_ff, dreg_in;
   logic [SRW-1:0]       srem_ff, srem_in;
   logic [RW-1:0]        root_ff, root_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [AXIS_W-1:0]    res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                 res_own_ff, res_own_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   logic                 own_valid_ff, own_valid_in;
   logic [ID_W-1:0]      own_id_ff, own_id_in;
   logic [AXIS_W-1:0]    held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [MW-1:0]        mul_a, mul_b;
   logic [SQW-1:0]       mul_p;
   logic [MW-1:0]        a_sel;
   logic [SQW-1:0]       sq_sel;
   logic [DVW-1:0]       divisor;
   logic [DVW:0]         rem_sh;
   logic                 qbit;
   logic [QW-1:0]        qnext;
   logic [SRW-1:0]       srem_sh, trial;
   logic [RW:0]          root_inc;
   logic [QW-1:0]        mag, mag_sat;
   logic [AXIS_W-1:0]    mag_ext, axis_val;

   assign {q_cmd, q_fid, q_sx, q_ax, q_sy, q_ay} = q_data;
   assign mul_p   = SQW'(mul_a) * SQW'(mul_b);
   assign a_sel   = axis_ff ? ay_ff : ax_ff;
   assign sq_sel  = axis_ff ? sqy_ff : sqx_ff;
   assign divisor = norm_ff ? t2_ff : DVW'({cfg.outer_dead_radius, 1'b0});
   assign rem_sh  = {rem_ff, numq_ff[QW-1]};
   assign qbit    = (rem_sh >= {1'b0, divisor});
   assign qnext   = {numq_ff[QW-2:0], qbit};
   assign srem_sh = {srem_ff[SRW-3:0], dreg_ff[DRW-1 -: 2]};
   assign trial   = SRW'({root_ff, 2'b01});
   assign root_inc = {1'b0, root_ff} + (RW + 1)'(1);
   assign mag     = norm_ff ? QW'(root_inc[RW:1]) : numq_ff;
   assign mag_sat = (mag > AXIS_MAX) ? AXIS_MAX : mag;
   assign mag_ext = AXIS_W'(mag_sat);

   always_comb begin
      if ((axis_ff ? sy_ff : sx_ff) ^ (axis_ff ? cfg.invert_y_axis : cfg.invert_x_axis)) begin
         axis_val = -mag_ext;
      end else begin
         axis_val = mag_ext;
      end
   end

   always_comb begin
      case (step_ff)
         3'd0: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         3'd1: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         3'd2: begin
            mul_a = MW'(cfg.active_radius);
            mul_b = MW'(cfg.active_radius);
         end
         3'd3: begin
            mul_a = MW'(cfg.inner_dead_radius);
            mul_b = MW'(cfg.inner_dead_radius);
         end
         3'd4: begin
            mul_a = MW'(cfg.outer_dead_radius);
            mul_b = MW'(cfg.outer_dead_radius);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      fid_in        = fid_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      ar2_in        = ar2_ff;
      ir2_in        = ir2_ff;
      or2_in        = or2_ff;
      t2_in         = t2_ff;
      step_in       = step_ff;
      norm_in       = norm_ff;
      axis_in       = axis_ff;
      q0_in         = q0_ff;
      rem_in        = rem_ff;
      numq_in       = numq_ff;
      cnt_in        = cnt_ff;
      dreg_in       = dreg_ff;
      srem_in       = srem_ff;
      root_in       = root_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_own_in    = res_own_ff;
      res_id_in     = res_id_ff;
      own_valid_in  = own_valid_ff;
      own_id_in     = own_id_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               fid_in = q_fid;
               ax_in  = q_ax;
               ay_in  = q_ay;
               sx_in  = q_sx;
               sy_in  = q_sy;
               if (q_cmd == CMD_RELEASE) begin
                  res_status_in = STATUS_NONE;
                  res_x_in      = '0;
                  res_y_in      = '0;
                  res_own_in    = 1'b0;
                  res_id_in     = '0;
                  state_in      = ST_DONE;
               end else if (own_valid_ff && (own_id_ff != q_fid)) begin
                  res_status_in = STATUS_NONE;
                  res_x_in      = held_x_ff;
                  res_y_in      = held_y_ff;
                  res_own_in    = own_valid_ff;
                  res_id_in     = own_id_ff;
                  state_in      = ST_DONE;
               end else begin
                  step_in  = '0;
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: sqx_in = mul_p;
               3'd1: sqy_in = mul_p;
               3'd2: ar2_in = mul_p;
               3'd3: ir2_in = mul_p;
               3'd4: or2_in = mul_p;
               default: begin
                  t2_in    = DVW'(sqx_ff) + DVW'(sqy_ff);
                  state_in = ST_CLASS;
               end
            endcase
         end
         ST_CLASS: begin
            res_x_in = '0;
            res_y_in = '0;
            if (t2_ff > DVW'(ar2_ff)) begin
               res_status_in = STATUS_NONE;
               res_own_in    = 1'b0;
               res_id_in     = '0;
               state_in      = ST_DONE;
            end else begin
               res_own_in = 1'b1;
               res_id_in  = fid_ff;
               if (t2_ff < DVW'(ir2_ff)) begin
                  res_status_in = STATUS_INNER;
                  state_in      = ST_DONE;
               end else begin
                  res_status_in = STATUS_ACTIVE;
                  norm_in       = (t2_ff > DVW'(or2_ff));
                  axis_in       = 1'b0;
                  state_in      = ST_DIVL;
               end
            end
         end
         ST_DIVL: begin
            if (norm_ff) begin
               q0_in    = (DVW'(sq_sel) >= t2_ff);
               rem_in   = (DVW'(sq_sel) >= t2_ff) ? '0 : DVW'(sq_sel);
               numq_in  = '0;
               cnt_in   = CNTW'(NORM_STEPS);
               state_in = ST_DIV;
            end else if (cfg.outer_dead_radius == '0) begin
               numq_in  = '0;
               state_in = ST_AXIS;
            end else begin
               rem_in   = '0;
               numq_in  = ((QW'(a_sel) << (F + 1)) + QW'(cfg.outer_dead_radius))
                          << (QW - LIN_STEPS);
               cnt_in   = CNTW'(LIN_STEPS);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? DVW'(rem_sh - {1'b0, divisor}) : DVW'(rem_sh);
            numq_in = qnext;
            cnt_in  = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               if (norm_ff) begin
                  dreg_in  = {1'b0, q0_ff, qnext[2*F+1:0]};
                  srem_in  = '0;
                  root_in  = '0;
                  cnt_in   = CNTW'(RW);
                  state_in = ST_SQRT;
               end else begin
                  state_in = ST_AXIS;
               end
            end
         end
         ST_SQRT: begin
            dreg_in = {dreg_ff[DRW-3:0], 2'b00};
            cnt_in  = cnt_ff - CNTW'(1);
            if (srem_sh >= trial) begin
               srem_in = srem_sh - trial;
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               srem_in = srem_sh;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            if (cnt_ff == CNTW'(1)) begin
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            if (axis_ff) begin
               res_y_in = axis_val;
               state_in = ST_DONE;
            end else begin
               res_x_in = axis_val;
               axis_in  = 1'b1;
               state_in = ST_DIVL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.touch_status  = res_status_ff;
               rsp_data_in.axis_x        = res_x_ff;
               rsp_data_in.axis_y        = res_y_ff;
               own_valid_in              = res_own_ff;
               own_id_in                 = res_id_ff;
               held_x_in                 = res_x_ff;
               held_y_in                 = res_y_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_valid_ff <= 1'b0;
         own_id_ff    <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_valid_ff <= own_valid_in;
         own_id_ff    <= own_id_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fid_ff        <= fid_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      ar2_ff        <= ar2_in;
      ir2_ff        <= ir2_in;
      or2_ff        <= or2_in;
      t2_ff         <= t2_in;
      step_ff       <= step_in;
      norm_ff       <= norm_in;
      axis_ff       <= axis_in;
      q0_ff         <= q0_in;
      rem_ff        <= rem_in;
      numq_ff       <= numq_in;
      cnt_ff        <= cnt_in;
      dreg_ff       <= dreg_in;
      srem_ff       <= srem_in;
      root_ff       <= root_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_own_ff    <= res_own_in;
      res_id_ff     <= res_id_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

### design/radial_touch_joystick_mapper_top.sv
// Maps trackpad touches onto a virtual circular joystick with inner and outer dead
// zones, one owning finger and per-axis inversion; axes are Q1.15, saturated.
// Items are handled one at a time by the back end: a release or a touch by a
// foreign finger goes straight to the result, a touch outside the active radius
// or in the inner dead zone passes the squaring steps and the classification,
// and a linear-zone or normalised-zone touch also passes the bit-serial divider
// and, for a normalised-zone touch, the bit-serial square root, both used once
// per axis. A two-entry queue behind the front end takes further beats while
// the back end works, and a result beat is held in its own register until it
// is taken. Depends on rtjm_pkg and the rtjm_front, rtjm_queue and rtjm_back
// modules.
module radial_touch_joystick_mapper_top #(
   parameter int FRAC_BITS  = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rtjm_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rtjm_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rtjm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtjm_pkg::CFG_W-1:0]     csr_wdata
);
   import rtjm_pkg::*;

   localparam int MW = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
   localparam int EW = 1 + ID_W + 2 * (MW + 1);

   cfg_type       cfg_ff, cfg_in;
   logic          q_full, q_push, q_pop, q_not_empty;
   logic [EW-1:0] q_wdata, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CENTER_X:   cfg_in.center_x          = csr_wdata;
            REG_CENTER_Y:   cfg_in.center_y          = csr_wdata;
            REG_ACTIVE_RAD: cfg_in.active_radius     = csr_wdata;
            REG_INNER_RAD:  cfg_in.inner_dead_radius = csr_wdata;
            REG_OUTER_RAD:  cfg_in.outer_dead_radius = csr_wdata;
            REG_INVERT_X:   cfg_in.invert_x_axis     = csr_wdata[0];
            REG_INVERT_Y:   cfg_in.invert_y_axis     = csr_wdata[0];
            default:        cfg_in                   = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x          <= '0;
         cfg_ff.center_y          <= '0;
         cfg_ff.active_radius     <= CFG_W'(1);
         cfg_ff.inner_dead_radius <= '0;
         cfg_ff.outer_dead_radius <= CFG_W'(1);
         cfg_ff.invert_x_axis     <= 1'b0;
         cfg_ff.invert_y_axis     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rtjm_front #(
      .COORD_BITS (COORD_BITS),
      .MW         (MW),
      .EW         (EW)
   ) u_front (
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .center_x  (cfg_ff.center_x),
      .center_y  (cfg_ff.center_y),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   rtjm_queue #(
      .W     (EW),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   rtjm_back #(
      .MW        (MW),
      .FRAC_BITS (FRAC_BITS),
      .EW        (EW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_not_empty),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

### dv/rtjm_checker.sv
// Checker for the radial touch joystick mapper: watches the request, result and
// register channels, predicts each result and compares it with the block's.
// Depends on rtjm_pkg.
`timescale 1ns / 100ps
module rtjm_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  rtjm_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  rtjm_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rtjm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtjm_pkg::CFG_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import rtjm_pkg::*;

   localparam longint unsigned AXIS_MAX = 32767;

   cfg_type           cfg;
   logic              owner_valid;
   logic [ID_W-1:0]   owner_id;
   logic signed [15:0] held_x, held_y;
   rsp_type           awaited_rsp[$];

   function automatic logic signed [15:0] apply_sign(longint unsigned mag, logic neg);
      longint unsigned m;
      m = (mag > AXIS_MAX) ? AXIS_MAX : mag;
      return neg ? -$signed(16'(m)) : $signed(16'(m));
   endfunction

   function automatic logic signed [15:0] linear_defl(longint d);
      longint unsigned a, r;
      a = (d < 0) ? -d : d;
      r = cfg.outer_dead_radius;
      if (r == 0) return 0;
      return apply_sign(((a << 16) + r) / (2 * r), d < 0);
   endfunction

   function automatic logic signed [15:0] norm_defl(longint d, longint unsigned t2);
      longint unsigned a, num, q, c;
      a = (d < 0) ? -d : d;
      num = (a * a) << 30;
      q = 0;
      for (int b = 15; b >= 0; b--) begin
         c = q | (64'd1 << b);
         if (c * c * t2 <= num) q = c;
      end
      if ((2 * q + 1) * (2 * q + 1) * t2 <= (num << 2)) q++;
      return apply_sign(q, d < 0);
   endfunction

   function automatic rsp_type map_touch(req_type r);
      rsp_type res;
      longint dx, dy;
      longint unsigned t2, ar, ir, orad;
      res.touch_status = STATUS_NONE;
      if (r.cmd == CMD_RELEASE) begin
         owner_valid = 1'b0;
         owner_id = '0;
         held_x = 0;
         held_y = 0;
      end else if (!(owner_valid && owner_id != r.finger)) begin
         dx = longint'(r.touch_x) - longint'(cfg.center_x);
         dy = longint'(r.touch_y) - longint'(cfg.center_y);
         t2 = dx * dx + dy * dy;
         ar = cfg.active_radius;
         ir = cfg.inner_dead_radius;
         orad = cfg.outer_dead_radius;
         held_x = 0;
         held_y = 0;
         if (t2 > ar * ar) begin
            owner_valid = 1'b0;
            owner_id = '0;
         end else begin
            owner_valid = 1'b1;
            owner_id = r.finger;
            if (t2 < ir * ir) begin
               res.touch_status = STATUS_INNER;
            end else begin
               res.touch_status = STATUS_ACTIVE;
               if (t2 <= orad * orad) begin
                  held_x = linear_defl(dx);
                  held_y = linear_defl(dy);
               end else begin
                  held_x = norm_defl(dx, t2);
                  held_y = norm_defl(dy, t2);
               end
               if (cfg.invert_x_axis) held_x = -held_x;
               if (cfg.invert_y_axis) held_y = -held_y;
            end
         end
      end
      res.axis_x = held_x;
      res.axis_y = held_y;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         cfg <= '{center_x: '0, center_y: '0, active_radius: 12'd1, inner_dead_radius: '0,
                  outer_dead_radius: 12'd1, invert_x_axis: 1'b0, invert_y_axis: 1'b0};
         owner_valid = 1'b0;
         owner_id = '0;
         held_x = 0;
         held_y = 0;
         fail_count <= 0;
         pending <= 0;
         awaited_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CENTER_X:   cfg.center_x <= csr_wdata;
               REG_CENTER_Y:   cfg.center_y <= csr_wdata;
               REG_ACTIVE_RAD: cfg.active_radius <= csr_wdata;
               REG_INNER_RAD:  cfg.inner_dead_radius <= csr_wdata;
               REG_OUTER_RAD:  cfg.outer_dead_radius <= csr_wdata;
               REG_INVERT_X:   cfg.invert_x_axis <= csr_wdata[0];
               REG_INVERT_Y:   cfg.invert_y_axis <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) awaited_rsp.push_back(map_touch(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = awaited_rsp.pop_front();
               if (rsp_data.touch_status !== exp_rsp.touch_status ||
                   rsp_data.axis_x !== exp_rsp.axis_x || rsp_data.axis_y !== exp_rsp.axis_y) begin
                  $display("%0t: mismatch expected status %0d x %0d y %0d, actual status %0d x %0d y %0d",
                           $time, exp_rsp.touch_status, exp_rsp.axis_x, exp_rsp.axis_y,
                           rsp_data.touch_status, rsp_data.axis_x, rsp_data.axis_y);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= awaited_rsp.size();
      end
   end
endmodule

### dv/tb_radial_touch_joystick_mapper_top.sv
// Testbench top for the radial touch joystick mapper: drives touches, releases and
// register writes with random idling, and gives the verdict.
// Depends on rtjm_pkg, radial_touch_joystick_mapper_top and rtjm_checker.
`timescale 1ns / 100ps
module tb_radial_touch_joystick_mapper_top;
   import rtjm_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 150;

   logic                 clock, reset;
   logic                 req_valid, req_stall, rsp_valid, rsp_stall;
   req_type              req_data;
   rsp_type              rsp_data;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int                   fail_count, pending, cycles;
   logic                 quiet;
   int                   stall_left;
   cfg_type              cur_cfg;
   logic [ID_W-1:0]      main_finger;

   radial_touch_joystick_mapper_top dut (.*);
   rtjm_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(cfg_type c);
      wait_idle();
      cur_cfg = c;
      write_reg(REG_CENTER_X, c.center_x);
      write_reg(REG_CENTER_Y, c.center_y);
      write_reg(REG_ACTIVE_RAD, c.active_radius);
      write_reg(REG_INNER_RAD, c.inner_dead_radius);
      write_reg(REG_OUTER_RAD, c.outer_dead_radius);
      write_reg(REG_INVERT_X, {11'd0, c.invert_x_axis});
      write_reg(REG_INVERT_Y, {11'd0, c.invert_y_axis});
   endtask

   task automatic send_beat(logic cmd, logic [ID_W-1:0] fid, logic [CFG_W-1:0] x,
                            logic [CFG_W-1:0] y);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: cmd, finger: fid, touch_x: x, touch_y: y};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [CFG_W-1:0] near_coord(logic [CFG_W-1:0] ctr);
      int span, v;
      span = cur_cfg.active_radius * 5 / 4 + 2;
      v = int'(ctr) + $urandom_range(0, 2 * span) - span;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[CFG_W-1:0];
   endfunction

   task automatic random_beats(int count);
      int kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 6)
            send_beat(CMD_RELEASE, ID_W'($urandom_range(0, 127)), CFG_W'($urandom),
                      CFG_W'($urandom));
         else if (kind < 14)
            send_beat(CMD_TOUCH, ID_W'($urandom_range(0, 127)), CFG_W'($urandom),
                      CFG_W'($urandom));
         else if (kind < 22)
            send_beat(CMD_TOUCH, ID_W'($urandom_range(0, 127)), near_coord(cur_cfg.center_x),
                      near_coord(cur_cfg.center_y));
         else begin
            if ($urandom_range(0, 30) == 0) main_finger = ID_W'($urandom_range(0, 127));
            send_beat(CMD_TOUCH, main_finger, near_coord(cur_cfg.center_x),
                      near_coord(cur_cfg.center_y));
         end
      end
   endtask

   initial begin
      cfg_type c;
      cycles = 0;
      quiet = 1'b0;
      stall_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cur_cfg = '{center_x: 0, center_y: 0, active_radius: 1, inner_dead_radius: 0,
                  outer_dead_radius: 1, invert_x_axis: 0, invert_y_axis: 0};
      main_finger = 7'd5;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(CMD_TOUCH, 7'd0, 12'd0, 12'd0);
      send_beat(CMD_TOUCH, 7'd0, 12'd1, 12'd0);
      send_beat(CMD_TOUCH, 7'd127, 12'd4095, 12'd4095);

      load_config('{center_x: 2048, center_y: 2048, active_radius: 1500,
                    inner_dead_radius: 100, outer_dead_radius: 800,
                    invert_x_axis: 0, invert_y_axis: 0});
      send_beat(CMD_TOUCH, 7'd3, 12'd2048, 12'd2048);
      send_beat(CMD_TOUCH, 7'd3, 12'd2448, 12'd1648);
      send_beat(CMD_TOUCH, 7'd9, 12'd2448, 12'd2448);
      send_beat(CMD_TOUCH, 7'd3, 12'd3548, 12'd2048);
      send_beat(CMD_TOUCH, 7'd3, 12'd2048, 12'd1048);
      send_beat(CMD_TOUCH, 7'd3, 12'd2848, 12'd2048);
      send_beat(CMD_TOUCH, 7'd3, 12'd2048, 12'd548);
      send_beat(CMD_TOUCH, 7'd3, 12'd4095, 12'd4095);
      send_beat(CMD_TOUCH, 7'd127, 12'd1000, 12'd2500);
      send_beat(CMD_RELEASE, 7'd64, 12'd4095, 12'd0);
      send_beat(CMD_TOUCH, 7'd0, 12'd0, 12'd0);

      load_config('{center_x: 1000, center_y: 3000, active_radius: 2000,
                    inner_dead_radius: 900, outer_dead_radius: 0,
                    invert_x_axis: 1, invert_y_axis: 1});
      send_beat(CMD_TOUCH, 7'd8, 12'd1000, 12'd3000);
      send_beat(CMD_TOUCH, 7'd8, 12'd1000, 12'd3900);
      send_beat(CMD_TOUCH, 7'd8, 12'd2100, 12'd2200);
      send_beat(CMD_TOUCH, 7'd8, 12'd0, 12'd4095);
      send_beat(CMD_RELEASE, 7'd0, 12'd0, 12'd0);

      load_config('{center_x: 0, center_y: 0, active_radius: 4095, inner_dead_radius: 0,
                    outer_dead_radius: 4095, invert_x_axis: 0, invert_y_axis: 1});
      random_beats(140);
      load_config('{center_x: 4095, center_y: 4095, active_radius: 4095,
                    inner_dead_radius: 4095, outer_dead_radius: 1,
                    invert_x_axis: 1, invert_y_axis: 0});
      random_beats(120);
      load_config('{center_x: 2048, center_y: 2048, active_radius: 1500,
                    inner_dead_radius: 100, outer_dead_radius: 800,
                    invert_x_axis: 1, invert_y_axis: 1});
      random_beats(150);
      for (int p = 0; p < 3; p++) begin
         c.center_x = CFG_W'($urandom);
         c.center_y = CFG_W'($urandom);
         c.active_radius = CFG_W'($urandom_range(1, 4095));
         c.inner_dead_radius = CFG_W'($urandom_range(0, c.active_radius / 2));
         c.outer_dead_radius = CFG_W'($urandom_range(c.inner_dead_radius, c.active_radius));
         c.invert_x_axis = 1'($urandom);
         c.invert_y_axis = 1'($urandom);
         load_config(c);
         if (p == 2) quiet = 1'b1;
         random_beats(140);
      end

      wait_idle();
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
